### hw/rtl/bps_pkg.sv
`timescale 1ns / 1ps

package bps_pkg;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_STOP    = 2'd3;

  localparam logic [2:0] PAT_NONE     = 3'd0;
  localparam logic [2:0] PAT_ONE_HZ   = 3'd1;
  localparam logic [2:0] PAT_TWO_HZ   = 3'd2;
  localparam logic [2:0] PAT_THREE_HZ = 3'd3;
  localparam logic [2:0] PAT_DOUBLE   = 3'd4;
  localparam logic [2:0] PAT_START    = 3'd5;
  localparam logic [2:0] PAT_OVER     = 3'd6;
  localparam logic [2:0] PAT_OVERTIME = 3'd7;

  localparam logic [11:0] T_BEEP_ON    = 12'd100;
  localparam logic [11:0] T_ONE_HZ_OFF = 12'd900;
  localparam logic [11:0] T_TWO_HZ_OFF = 12'd400;
  localparam logic [11:0] T_THREE_OFF  = 12'd233;
  localparam logic [11:0] T_DBL_GAP    = 12'd150;
  localparam logic [11:0] T_DBL_PAUSE  = 12'd650;
  localparam logic [11:0] T_START_TONE = 12'd2000;
  localparam logic [11:0] T_OVER_TONE  = 12'd3000;

  localparam logic [15:0] OT_FULL_RESET = 16'd10000;

  // 65536000 = 1000 << 16: high part preloads the remainder
  localparam logic [18:0] PERIOD_NUM_HI = 19'd1000;
  localparam logic [4:0]  DIV1_STEPS    = 5'd17;
  localparam logic [4:0]  DIV2_STEPS    = 5'd16;

  typedef struct packed {
    logic        load;
    logic [18:0] r_init;
    logic [16:0] n_init;
    logic [18:0] divisor;
    logic [4:0]  steps;
  } div_load_t;

endpackage

### hw/rtl/bps_divider.sv
`timescale 1ns / 1ps

module bps_divider
  import bps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_load_t   ld,
  output logic        busy,
  output logic [16:0] quotient
);

  logic [18:0] rem;
  logic [16:0] num;
  logic [18:0] div;
  logic [4:0]  cnt;
  logic [19:0] trial;
  logic        geq;

  assign trial = {rem, num[16]};
  assign geq   = trial >= {1'b0, div};
  assign busy  = cnt != 5'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 5'd0;
    end else if (ld.load) begin
      cnt <= ld.steps;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      rem      <= ld.r_init;
      num      <= ld.n_init;
      div      <= ld.divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= geq ? 19'(trial - {1'b0, div}) : trial[18:0];
      num      <= {num[15:0], 1'b0};
      quotient <= {quotient[15:0], geq};
    end
  end

endmodule

### hw/rtl/beep_pattern_sequencer.sv
`timescale 1ns / 1ps

// Buzzer pattern sequencer. Each transfer on s_* is one command; each command
// yields exactly one transfer on m_* with the buzzer level and running pattern.
// One command is handled at a time: most go from accept through an evaluate
// state to the result; a tick ending an overtime beep also runs the shared
// shift-subtract divider for 17 steps (remaining/full ratio), one squaring
// step, then 16 steps (period). The user writes overtime_full_ms through
// cfg_we/cfg_wdata only while idle; the block does not enforce it. Zero acts as 1.
module beep_pattern_sequencer
  import bps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] now_ms, [63:32] ot_left_ms
  input  logic [4:0]  s_tuser,   // [1:0] cmd, [4:2] pattern
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] buzzer_on, [3:1] active_pattern, [7:4] zero
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]  state;
  logic [2:0]  state_next;
  logic [15:0] ot_full;

  logic [1:0]  in_cmd;
  logic [2:0]  in_pat;
  logic [31:0] in_now;
  logic [31:0] in_rem;

  logic [2:0]  cur_pat;
  logic [31:0] next_change;
  logic [1:0]  beep_cnt;
  logic        tone;
  logic [2:0]  cur_pat_next;
  logic [31:0] next_change_next;
  logic [1:0]  beep_cnt_next;
  logic        tone_next;

  logic [16:0] p_val;
  logic [9:0]  off_ms;

  div_load_t   div_ld;
  logic        div_busy;
  logic [16:0] div_q;

  logic [15:0] full_eff;
  logic [15:0] rem16;
  logic        due;
  logic        ot_off;
  logic [33:0] prod;
  logic [18:0] f_val;
  logic [9:0]  period;
  logic        commit;
  logic [11:0] delay;
  logic        set_delay;
  logic [1:0]  bc_inc;

  bps_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .ld       (div_ld),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign s_tready = state == S_IDLE;
  assign commit   = (state == S_DONE) && (!m_tvalid || m_tready);

  assign full_eff = (ot_full == 16'd0) ? 16'd1 : ot_full;
  assign rem16    = (in_rem < {16'd0, full_eff}) ? in_rem[15:0] : full_eff;
  assign due      = (cur_pat != PAT_NONE) && (in_now >= next_change);
  assign ot_off   = (in_cmd == CMD_TICK) && (cur_pat == PAT_OVERTIME) && due && tone;
  assign prod     = p_val * p_val;
  assign f_val    = 19'h10000 + {prod[32:16], 2'b00};
  assign period   = div_q[9:0];
  assign bc_inc   = beep_cnt + 2'd1;

  always_comb begin
    div_ld = '0;
    if (state == S_EVAL && ot_off) begin
      div_ld.load    = 1'b1;
      div_ld.r_init  = {4'd0, rem16[15:1]};
      div_ld.n_init  = {rem16[0], 16'd0};
      div_ld.divisor = {3'd0, full_eff};
      div_ld.steps   = DIV1_STEPS;
    end else if (state == S_MUL) begin
      div_ld.load    = 1'b1;
      div_ld.r_init  = PERIOD_NUM_HI;
      div_ld.n_init  = '0;
      div_ld.divisor = f_val;
      div_ld.steps   = DIV2_STEPS;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = S_EVAL;
      S_EVAL: state_next = ot_off ? S_DIV1 : S_DONE;
      S_DIV1: if (!div_busy) state_next = S_MUL;
      S_MUL:  state_next = S_DIV2;
      S_DIV2: if (!div_busy) state_next = S_DONE;
      S_DONE: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cur_pat_next     = cur_pat;
    next_change_next = next_change;
    beep_cnt_next    = beep_cnt;
    tone_next        = tone;
    delay            = T_BEEP_ON;
    set_delay        = 1'b0;
    unique case (in_cmd)
      CMD_TICK: begin
        if (due) begin
          unique case (cur_pat)
            PAT_ONE_HZ, PAT_TWO_HZ, PAT_THREE_HZ, PAT_OVERTIME: begin
              tone_next = !tone;
              set_delay = 1'b1;
              if (tone) begin
                unique case (cur_pat)
                  PAT_ONE_HZ:   delay = T_ONE_HZ_OFF;
                  PAT_TWO_HZ:   delay = T_TWO_HZ_OFF;
                  PAT_THREE_HZ: delay = T_THREE_OFF;
                  default:      delay = {2'd0, off_ms};
                endcase
              end
            end
            PAT_DOUBLE: begin
              tone_next = !tone;
              set_delay = 1'b1;
              if (tone) begin
                if (bc_inc < 2'd2) begin
                  beep_cnt_next = bc_inc;
                  delay         = T_DBL_GAP;
                end else begin
                  beep_cnt_next = 2'd0;
                  delay         = T_DBL_PAUSE;
                end
              end
            end
            PAT_START: begin
              if (beep_cnt < 2'd3) begin
                tone_next = !tone;
                set_delay = 1'b1;
                if (tone) begin
                  beep_cnt_next = bc_inc;
                  if (bc_inc < 2'd3) begin
                    delay = T_ONE_HZ_OFF;
                  end else begin
                    tone_next = 1'b1;
                    delay     = T_START_TONE;
                  end
                end
              end else begin
                tone_next    = 1'b0;
                cur_pat_next = PAT_NONE;
              end
            end
            PAT_OVER: begin
              if (!tone) begin
                tone_next = 1'b1;
                set_delay = 1'b1;
                delay     = T_OVER_TONE;
              end else begin
                tone_next    = 1'b0;
                cur_pat_next = PAT_NONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      CMD_START, CMD_RESTART: begin
        if (in_cmd == CMD_RESTART || cur_pat != in_pat) begin
          cur_pat_next     = in_pat;
          beep_cnt_next    = 2'd0;
          tone_next        = 1'b0;
          next_change_next = in_now;
        end
      end
      CMD_STOP: begin
        if (cur_pat != PAT_NONE) begin
          cur_pat_next = PAT_NONE;
          tone_next    = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (set_delay) next_change_next = in_now + {20'd0, delay};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ot_full     <= OT_FULL_RESET;
      cur_pat     <= PAT_NONE;
      next_change <= 32'd0;
      beep_cnt    <= 2'd0;
      tone        <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) ot_full <= cfg_wdata;
      if (commit) begin
        cur_pat     <= cur_pat_next;
        next_change <= next_change_next;
        beep_cnt    <= beep_cnt_next;
        tone        <= tone_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= s_tuser[1:0];
      in_pat <= s_tuser[4:2];
      in_now <= s_tdata[31:0];
      in_rem <= s_tdata[63:32];
    end
    if (state == S_DIV1 && !div_busy) p_val <= 17'h10000 - div_q;
    if (state == S_DIV2 && !div_busy) begin
      off_ms <= (period > 10'd100) ? 10'(period - 10'd100) : 10'd1;
    end
    if (commit) m_tdata <= {4'd0, cur_pat_next, tone_next};
  end

endmodule

### hw/rtl/bps_checker.sv
`timescale 1ns / 1ps

module bps_checker
  import bps_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command taken while previous one in progress");

  a_tone_needs_pattern: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[3:1] != PAT_NONE)
    else $error("buzzer on with no pattern running");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:4] == 4'd0)
    else $error("result padding not zero");

endmodule

bind beep_pattern_sequencer bps_checker u_bps_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tvalid  (s_tvalid),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata)
);
